@@ hw/rtl/alarm_and_night_window_scheduler_defines.svh @@
// Assertion helpers for the alarm and night-window scheduler.
// Both sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef ALARM_AND_NIGHT_WINDOW_SCHEDULER_DEFINES_SVH
`define ALARM_AND_NIGHT_WINDOW_SCHEDULER_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define ANWS_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define ANWS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/anws_pkg.sv @@
`default_nettype none

package anws_pkg;

    // Field widths
    localparam int WEEKDAY_W   = 3;
    localparam int HOUR_W      = 5;
    localparam int MINUTE_W    = 6;
    localparam int SECOND_W    = 6;
    localparam int ENABLES_W   = 2;
    localparam int ELAPSED_W   = 6;
    localparam int CFG_DATA_W  = 6;
    localparam int CFG_INDEX_W = 3;
    // Minutes of the day as raw values: 60 * 31 + 63 fits in 11 bits
    localparam int DAYMIN_W    = 11;

    // Alarm only starts in the first 50 seconds of the minute
    localparam logic [SECOND_W-1:0] SECOND_LIMIT = 6'd50;

    // Enable bits
    localparam int EN_ALARM = 0;
    localparam int EN_NIGHT = 1;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ENABLES      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ALARM_DAY    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ALARM_HOUR   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ALARM_MIN    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_NIGHT_S_HOUR = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_NIGHT_S_MIN  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_NIGHT_E_HOUR = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_NIGHT_E_MIN  = 3'd7;

    // Register reset values
    localparam logic [ENABLES_W-1:0] RST_ENABLES      = 2'd0;
    localparam logic [WEEKDAY_W-1:0] RST_ALARM_DAY    = 3'd5;
    localparam logic [HOUR_W-1:0]    RST_ALARM_HOUR   = 5'd0;
    localparam logic [MINUTE_W-1:0]  RST_ALARM_MIN    = 6'd33;
    localparam logic [HOUR_W-1:0]    RST_NIGHT_S_HOUR = 5'd22;
    localparam logic [MINUTE_W-1:0]  RST_NIGHT_S_MIN  = 6'd26;
    localparam logic [HOUR_W-1:0]    RST_NIGHT_E_HOUR = 5'd5;
    localparam logic [MINUTE_W-1:0]  RST_NIGHT_E_MIN  = 6'd59;

    typedef struct packed {
        logic [WEEKDAY_W-1:0] weekday;
        logic [HOUR_W-1:0]    hour_now;
        logic [MINUTE_W-1:0]  minute_now;
        logic [SECOND_W-1:0]  second_now;
        logic                 stop_request;
    } anws_in_t;

    typedef struct packed {
        logic buzzer_on;
        logic alarm_showing;
        logic night_now;
        logic night_entered;
        logic night_left;
    } anws_out_t;

    typedef struct packed {
        logic [HOUR_W-1:0]   start_hour;
        logic [MINUTE_W-1:0] start_minute;
        logic [HOUR_W-1:0]   end_hour;
        logic [MINUTE_W-1:0] end_minute;
    } anws_night_cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/anws_night_window.sv @@
`default_nettype none

module anws_night_window (
    input  anws_pkg::anws_night_cfg_t          cfg,
    input  wire logic [anws_pkg::HOUR_W-1:0]   hour,
    input  wire logic [anws_pkg::MINUTE_W-1:0] minute,
    output logic                               in_span
);
    import anws_pkg::*;

    // 60 * hour + minute as shifts and one subtract
    function automatic logic [DAYMIN_W-1:0] day_minutes(
        input logic [HOUR_W-1:0]   h,
        input logic [MINUTE_W-1:0] m
    );
        logic [DAYMIN_W-1:0] hx;
        hx = DAYMIN_W'(h);
        return (hx << 6) - (hx << 2) + DAYMIN_W'(m);
    endfunction

    logic [DAYMIN_W-1:0] now_min;
    logic [DAYMIN_W-1:0] start_min;
    logic [DAYMIN_W-1:0] end_min;
    logic                all_day;
    logic                after_start;
    logic                before_end;

    assign now_min     = day_minutes(hour, minute);
    assign start_min   = day_minutes(cfg.start_hour, cfg.start_minute);
    assign end_min     = day_minutes(cfg.end_hour, cfg.end_minute);
    assign all_day     = (cfg.start_hour == cfg.end_hour) &&
                         (cfg.start_minute == cfg.end_minute);
    assign after_start = start_min <= now_min;
    assign before_end  = now_min <= end_min;

    // Pick the whole day, the plain span or the span that wraps midnight
    always_comb
    begin
        priority if (all_day)
        begin
            in_span = 1'b1;
        end
        else if (cfg.start_hour <= cfg.end_hour)
        begin
            in_span = after_start && before_end;
        end
        else
        begin
            in_span = after_start || before_end;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/alarm_and_night_window_scheduler.sv @@
// Alarm and night-window scheduler: takes one time word per second (weekday, hour,
// minute, second, stop request) and returns one status word per tick with the
// buzzer level, whether the alarm is showing, the held night flag and its entry and
// exit strobes. Throughput is one word per clock cycle unless out_ready stalls it;
// a word passes the input then the result register, and the state update (stop
// flag, elapsed counter, buzzer, night flag) is a single combinational pass between
// them. Configuration registers are to be written by the user only while no word
// is in flight, through the cfg_write/cfg_index/cfg_data port; the block does not
// enforce it. After reset: enables 0, alarm day 5 00:33, night 22:26 to 05:59.
`default_nettype none

module alarm_and_night_window_scheduler #(
    parameter int ALARM_SECONDS = 60
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  anws_pkg::anws_in_t                    in_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output anws_pkg::anws_out_t                   out_data,
    input  wire logic                             cfg_write,
    input  wire logic [anws_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [anws_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import anws_pkg::*;

    `include "alarm_and_night_window_scheduler_defines.svh"

    localparam logic [ELAPSED_W-1:0] ALARM_LIMIT = ELAPSED_W'(ALARM_SECONDS);
    localparam logic [ELAPSED_W-1:0] ALARM_LAST  = ELAPSED_W'(ALARM_SECONDS - 1);

    // Configuration registers
    logic [ENABLES_W-1:0] enables_reg;
    logic [WEEKDAY_W-1:0] alarm_day_reg;
    logic [HOUR_W-1:0]    alarm_hour_reg;
    logic [MINUTE_W-1:0]  alarm_min_reg;
    anws_night_cfg_t      night_cfg_reg;

    // Pipeline registers
    logic      in_valid_reg;
    anws_in_t  in_word_reg;
    logic      out_valid_reg;
    anws_out_t out_word_reg;
    anws_out_t out_word_next;
    logic      advance;

    // Scheduler state
    logic                 buzzer_reg;
    logic                 buzzer_next;
    logic                 stop_reg;
    logic                 stop_next;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [ELAPSED_W-1:0] elapsed_next;
    logic                 night_reg;
    logic                 night_next;

    logic night_inside;
    logic timeout;
    logic buzzer_mid;
    logic stop_mid;
    logic alarm_hit;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enables_reg                <= RST_ENABLES;
            alarm_day_reg              <= RST_ALARM_DAY;
            alarm_hour_reg             <= RST_ALARM_HOUR;
            alarm_min_reg              <= RST_ALARM_MIN;
            night_cfg_reg.start_hour   <= RST_NIGHT_S_HOUR;
            night_cfg_reg.start_minute <= RST_NIGHT_S_MIN;
            night_cfg_reg.end_hour     <= RST_NIGHT_E_HOUR;
            night_cfg_reg.end_minute   <= RST_NIGHT_E_MIN;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ENABLES:      enables_reg                <= cfg_data[ENABLES_W-1:0];
                REG_ALARM_DAY:    alarm_day_reg              <= cfg_data[WEEKDAY_W-1:0];
                REG_ALARM_HOUR:   alarm_hour_reg             <= cfg_data[HOUR_W-1:0];
                REG_ALARM_MIN:    alarm_min_reg              <= cfg_data[MINUTE_W-1:0];
                REG_NIGHT_S_HOUR: night_cfg_reg.start_hour   <= cfg_data[HOUR_W-1:0];
                REG_NIGHT_S_MIN:  night_cfg_reg.start_minute <= cfg_data[MINUTE_W-1:0];
                REG_NIGHT_E_HOUR: night_cfg_reg.end_hour     <= cfg_data[HOUR_W-1:0];
                REG_NIGHT_E_MIN:  night_cfg_reg.end_minute   <= cfg_data[MINUTE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Move the held word into the result register when that register is free
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Track valid bits of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (!out_valid_reg || out_ready)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_word_reg <= in_data;
        end
        if (advance)
        begin
            out_word_reg <= out_word_next;
        end
    end

    anws_night_window u_night_window (
        .cfg     (night_cfg_reg),
        .hour    (in_word_reg.hour_now),
        .minute  (in_word_reg.minute_now),
        .in_span (night_inside)
    );

    // Step the scheduler for the held word
    assign timeout    = elapsed_reg == ALARM_LAST;
    assign buzzer_mid = buzzer_reg && !timeout;
    assign stop_mid   = (stop_reg || in_word_reg.stop_request) && !timeout;
    assign alarm_hit  = enables_reg[EN_ALARM] &&
                        (in_word_reg.weekday == alarm_day_reg) &&
                        (in_word_reg.hour_now == alarm_hour_reg) &&
                        (in_word_reg.minute_now == alarm_min_reg) &&
                        (in_word_reg.second_now < SECOND_LIMIT) &&
                        !buzzer_mid && !stop_mid;

    always_comb
    begin
        stop_next = stop_mid;
        if (alarm_hit)
        begin
            buzzer_next  = 1'b1;
            elapsed_next = '0;
        end
        else
        begin
            buzzer_next  = buzzer_mid;
            elapsed_next = (elapsed_reg < ALARM_LIMIT) ? elapsed_reg + 1'b1 : elapsed_reg;
        end

        // Night flag follows the window only while night mode is on
        night_next = enables_reg[EN_NIGHT] ? night_inside : night_reg;

        out_word_next.buzzer_on     = buzzer_next;
        out_word_next.alarm_showing = !stop_next && (elapsed_next < ALARM_LIMIT);
        out_word_next.night_now     = night_next;
        out_word_next.night_entered = night_next && !night_reg;
        out_word_next.night_left    = !night_next && night_reg;
    end

    // Commit state once per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buzzer_reg  <= 1'b0;
            stop_reg    <= 1'b0;
            elapsed_reg <= ALARM_LIMIT;
            night_reg   <= 1'b0;
        end
        else if (advance)
        begin
            buzzer_reg  <= buzzer_next;
            stop_reg    <= stop_next;
            elapsed_reg <= elapsed_next;
            night_reg   <= night_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    // Checks
    `ANWS_ASSERT_SAME(a_elapsed_bound, 1'b1, elapsed_reg <= ALARM_LIMIT,
                      "elapsed count past limit")
    `ANWS_ASSERT_SAME(a_start_rings, elapsed_reg == '0, buzzer_reg,
                      "alarm restarted with buzzer off")
    `ANWS_ASSERT_NEXT(a_buzzer_off_timeout, buzzer_reg && !timeout, buzzer_reg,
                      "buzzer off before timeout")
    `ANWS_ASSERT_SAME(a_edges_exclusive, out_valid_reg,
                      !(out_word_reg.night_entered && out_word_reg.night_left),
                      "night entry and exit together")

endmodule

`default_nettype wire

@@ tb/sv/alarm_and_night_window_scheduler_tb.sv @@
`default_nettype none

module alarm_and_night_window_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import anws_pkg::*;

    localparam int ALARM_TICKS  = 60;
    localparam int DAY_SECONDS  = 86400;
    localparam int WEEK_SECONDS = 7 * DAY_SECONDS;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_TICKS  = 64;
    localparam int STOP_PCT     = 5;
    localparam int IN_W         = $bits(anws_in_t);

    // Track the scheduler state and the status words it owes
    class tick_status_board #(int unsigned LIMIT = 60);
        logic [ENABLES_W-1:0] enables;
        logic [WEEKDAY_W-1:0] alarm_day;
        logic [HOUR_W-1:0]    alarm_hour;
        logic [MINUTE_W-1:0]  alarm_min;
        anws_night_cfg_t      window;
        bit                   buzzer;
        bit                   stop_set;
        bit                   at_night;
        int unsigned          elapsed;
        anws_out_t            status_due[$];
        int unsigned          ticks_noted;
        int unsigned          words_checked;
        int unsigned          mismatches;
        int unsigned          alarms_started;
        int unsigned          stops_seen;
        int unsigned          entries;
        int unsigned          exits;

        function new();
            enables             = RST_ENABLES;
            alarm_day           = RST_ALARM_DAY;
            alarm_hour          = RST_ALARM_HOUR;
            alarm_min           = RST_ALARM_MIN;
            window.start_hour   = RST_NIGHT_S_HOUR;
            window.start_minute = RST_NIGHT_S_MIN;
            window.end_hour     = RST_NIGHT_E_HOUR;
            window.end_minute   = RST_NIGHT_E_MIN;
            buzzer              = 1'b0;
            stop_set            = 1'b0;
            at_night            = 1'b0;
            elapsed             = LIMIT;
        endfunction

        // Keep only the bits each register holds
        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ENABLES:      enables = data[ENABLES_W-1:0];
                REG_ALARM_DAY:    alarm_day = data[WEEKDAY_W-1:0];
                REG_ALARM_HOUR:   alarm_hour = data[HOUR_W-1:0];
                REG_ALARM_MIN:    alarm_min = data[MINUTE_W-1:0];
                REG_NIGHT_S_HOUR: window.start_hour = data[HOUR_W-1:0];
                REG_NIGHT_S_MIN:  window.start_minute = data[MINUTE_W-1:0];
                REG_NIGHT_E_HOUR: window.end_hour = data[HOUR_W-1:0];
                REG_NIGHT_E_MIN:  window.end_minute = data[MINUTE_W-1:0];
                default: ;
            endcase
        endfunction

        // Compare raw minutes of the day against the window
        function bit in_window(logic [HOUR_W-1:0] h, logic [MINUTE_W-1:0] m);
            int unsigned now_min;
            int unsigned open_min;
            int unsigned close_min;
            if (window.start_hour == window.end_hour &&
                window.start_minute == window.end_minute)
                return 1'b1;
            now_min   = 60 * int'(h) + int'(m);
            open_min  = 60 * int'(window.start_hour) + int'(window.start_minute);
            close_min = 60 * int'(window.end_hour) + int'(window.end_minute);
            if (window.start_hour <= window.end_hour)
                return open_min <= now_min && now_min <= close_min;
            return open_min <= now_min || now_min <= close_min;
        endfunction

        // Advance the state by one accepted tick and queue its status word
        function void note_tick(anws_in_t w);
            anws_out_t want;
            bit        night_hit;
            want = '0;
            ticks_noted++;
            if (w.stop_request)
            begin
                stop_set = 1'b1;
                stops_seen++;
            end
            if (elapsed == LIMIT - 1)
            begin
                buzzer   = 1'b0;
                stop_set = 1'b0;
            end
            if (elapsed < LIMIT)
                elapsed++;
            if (enables[EN_ALARM] && w.weekday == alarm_day && w.hour_now == alarm_hour &&
                w.minute_now == alarm_min && w.second_now < SECOND_LIMIT &&
                !buzzer && !stop_set)
            begin
                buzzer  = 1'b1;
                elapsed = 0;
                alarms_started++;
            end
            if (enables[EN_NIGHT])
            begin
                night_hit          = in_window(w.hour_now, w.minute_now);
                want.night_entered = night_hit && !at_night;
                want.night_left    = !night_hit && at_night;
                entries += want.night_entered;
                exits   += want.night_left;
                at_night = night_hit;
            end
            want.buzzer_on     = buzzer;
            want.alarm_showing = !stop_set && elapsed < LIMIT;
            want.night_now     = at_night;
            status_due.push_back(want);
        endfunction

        // Compare a status word with the oldest one owed
        function void check_status(anws_out_t got);
            anws_out_t want;
            if (status_due.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected status word %b at %0t", got, $realtime);
                mismatches++;
                return;
            end
            want = status_due.pop_front();
            words_checked++;
            if (got.buzzer_on !== want.buzzer_on || got.alarm_showing !== want.alarm_showing ||
                got.night_now !== want.night_now || got.night_entered !== want.night_entered ||
                got.night_left !== want.night_left)
            begin
                if (mismatches < 10)
                    $display("word %0d mismatch (buzzer/showing/night/in/out): want %b%b%b%b%b, got %b%b%b%b%b",
                             words_checked, want.buzzer_on, want.alarm_showing, want.night_now,
                             want.night_entered, want.night_left, got.buzzer_on,
                             got.alarm_showing, got.night_now, got.night_entered, got.night_left);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return status_due.size();
        endfunction

        function bit period_running();
            return elapsed < LIMIT;
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    anws_in_t               in_data;
    logic                   out_valid;
    logic                   out_ready;
    anws_out_t              out_data;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    tick_status_board #(ALARM_TICKS) sb;

    int unsigned send_gap_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_left;
    bit          idle_stops_ok;

    alarm_and_night_window_scheduler #(
        .ALARM_SECONDS(ALARM_TICKS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Break off a hung run
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // Drive the result side: long hold-offs first, then random stalls
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check every status word taken
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_status(out_data);
    end

    // Stops are only sent while an alarm period runs, except at the very end,
    // since a stop taken while idle blocks the alarm for good
    function automatic bit pick_stop();
        return (idle_stops_ok || sb.period_running()) && ($urandom_range(99) < STOP_PCT);
    endfunction

    function automatic anws_in_t time_word(int unsigned sow, bit stop);
        anws_in_t w;
        w.weekday      = WEEKDAY_W'(sow / DAY_SECONDS);
        w.hour_now     = HOUR_W'((sow % DAY_SECONDS) / 3600);
        w.minute_now   = MINUTE_W'((sow % 3600) / 60);
        w.second_now   = SECOND_W'(sow % 60);
        w.stop_request = stop;
        return w;
    endfunction

    // Offer one word after a random gap and hold it until taken
    task automatic send_tick(input anws_in_t w);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_tick(w);
    endtask

    task automatic send_at(input int unsigned wd, input int unsigned h, input int unsigned m,
                           input int unsigned s, input bit stop);
        anws_in_t w;
        w.weekday      = WEEKDAY_W'(wd);
        w.hour_now     = HOUR_W'(h);
        w.minute_now   = MINUTE_W'(m);
        w.second_now   = SECOND_W'(s);
        w.stop_request = stop;
        send_tick(w);
    endtask

    // Write a register, with random bits above its width
    task automatic write_field(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value,
                               input int unsigned width);
        int unsigned           mask;
        logic [CFG_DATA_W-1:0] data;
        mask = (1 << width) - 1;
        data = CFG_DATA_W'(($urandom() & ~mask) | (value & mask));
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    // Stop offering and wait until every owed word has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned       target;
        int unsigned       pick;
        int unsigned       sow;
        int unsigned       len;
        int unsigned       step;
        int unsigned       bound_min;
        int unsigned       back;
        int unsigned       s0;
        int unsigned       en;
        int unsigned       a_day;
        int unsigned       a_hour;
        int unsigned       a_min;
        int unsigned       s_hour;
        int unsigned       s_min;
        int unsigned       e_hour;
        int unsigned       e_min;
        anws_in_t          w;
        logic [IN_W-1:0]   raw;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        sb = new();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        idle_stops_ok  = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: both functions off, extreme words
        send_at(0, 0, 0, 0, 0);
        send_at(7, 31, 63, 63, 0);
        drain();

        // Alarm at the last minute of the week, window wrapping midnight
        write_field(REG_ENABLES, 3, ENABLES_W);
        write_field(REG_ALARM_DAY, 6, WEEKDAY_W);
        write_field(REG_ALARM_HOUR, 23, HOUR_W);
        write_field(REG_ALARM_MIN, 59, MINUTE_W);
        write_field(REG_NIGHT_S_HOUR, 22, HOUR_W);
        write_field(REG_NIGHT_S_MIN, 0, MINUTE_W);
        write_field(REG_NIGHT_E_HOUR, 6, HOUR_W);
        write_field(REG_NIGHT_E_MIN, 0, MINUTE_W);
        cfg_write <= 1'b0;
        send_at(6, 23, 59, 49, 0);
        send_at(6, 23, 59, 50, 1);
        send_at(0, 0, 0, 0, 0);
        send_at(0, 6, 0, 0, 0);
        send_at(0, 6, 1, 0, 0);
        send_at(0, 22, 0, 0, 0);
        send_at(7, 31, 63, 63, 0);
        drain();

        // Equal start and end: whole day is night
        write_field(REG_NIGHT_S_HOUR, 12, HOUR_W);
        write_field(REG_NIGHT_S_MIN, 30, MINUTE_W);
        write_field(REG_NIGHT_E_HOUR, 12, HOUR_W);
        write_field(REG_NIGHT_E_MIN, 30, MINUTE_W);
        cfg_write <= 1'b0;
        send_at(3, 1, 0, 0, 0);
        send_at(3, 13, 0, 0, 0);
        drain();

        // Equal hours with start minute past end minute: empty window
        write_field(REG_NIGHT_S_HOUR, 10, HOUR_W);
        write_field(REG_NIGHT_S_MIN, 40, MINUTE_W);
        write_field(REG_NIGHT_E_HOUR, 10, HOUR_W);
        write_field(REG_NIGHT_E_MIN, 20, MINUTE_W);
        cfg_write <= 1'b0;
        send_at(3, 10, 30, 0, 0);
        send_at(3, 10, 40, 0, 0);
        drain();

        // Window inside one day, both ends inclusive
        write_field(REG_NIGHT_S_HOUR, 8, HOUR_W);
        write_field(REG_NIGHT_S_MIN, 0, MINUTE_W);
        write_field(REG_NIGHT_E_HOUR, 17, HOUR_W);
        write_field(REG_NIGHT_E_MIN, 0, MINUTE_W);
        cfg_write <= 1'b0;
        send_at(3, 7, 59, 59, 0);
        send_at(3, 8, 0, 0, 0);
        send_at(3, 17, 0, 59, 0);
        drain();

        // Night mode off while the flag is set: hold it, no strobes
        write_field(REG_ENABLES, 1, ENABLES_W);
        cfg_write <= 1'b0;
        send_at(3, 20, 0, 0, 0);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            drain();
            en     = 3;
            a_day  = $urandom_range(6);
            a_hour = $urandom_range(23);
            a_min  = $urandom_range(59);
            s_hour = $urandom_range(23);
            s_min  = $urandom_range(59);
            e_hour = $urandom_range(23);
            e_min  = $urandom_range(59);
            case (p)
                0:
                begin
                    s_hour = $urandom_range(23, 18);
                    e_hour = $urandom_range(8);
                end
                1:
                begin
                    en     = 1;
                    a_day  = 0;
                    a_hour = 0;
                    a_min  = 0;
                end
                2:
                begin
                    en     = 2;
                    s_hour = $urandom_range(11, 6);
                    e_hour = $urandom_range(20, 12);
                end
                3:
                begin
                    a_day  = 6;
                    a_hour = 23;
                    a_min  = 59;
                    e_hour = s_hour;
                    e_min  = s_min;
                end
                4:
                begin
                    e_hour = s_hour;
                    s_min  = $urandom_range(59, 30);
                    e_min  = $urandom_range(29);
                end
                5:
                begin
                    a_day  = 7;
                    a_hour = $urandom_range(31, 24);
                    a_min  = $urandom_range(63, 60);
                    s_hour = $urandom_range(31);
                    s_min  = $urandom_range(63);
                    e_hour = $urandom_range(31);
                    e_min  = $urandom_range(63);
                end
                6: en = 0;
                default: ;
            endcase
            write_field(REG_ENABLES, en, ENABLES_W);
            write_field(REG_ALARM_DAY, a_day, WEEKDAY_W);
            write_field(REG_ALARM_HOUR, a_hour, HOUR_W);
            write_field(REG_ALARM_MIN, a_min, MINUTE_W);
            write_field(REG_NIGHT_S_HOUR, s_hour, HOUR_W);
            write_field(REG_NIGHT_S_MIN, s_min, MINUTE_W);
            write_field(REG_NIGHT_E_HOUR, e_hour, HOUR_W);
            write_field(REG_NIGHT_E_MIN, e_min, MINUTE_W);
            cfg_write <= 1'b0;

            // Rotate the idle pattern; fill the block against a held-off receiver
            case (p % 4)
                0:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                    hold_left      = 200;
                end
                1:
                begin
                    send_gap_pct   = 86;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 86;
                end
                default:
                begin
                    send_gap_pct   = 33;
                    recv_stall_pct = 33;
                end
            endcase
            idle_stops_ok = (p == PHASE_COUNT - 1);

            target = sb.ticks_noted + PHASE_TICKS;
            while (sb.ticks_noted < target)
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                begin
                    if (sb.alarm_day > 6 || sb.alarm_hour > 23 || sb.alarm_min > 59)
                    begin
                        // Unreachable alarm time: walk raw seconds at it
                        s0 = $urandom_range(45, 30);
                        for (int s = s0; s < 64; s++)
                        begin
                            w.weekday      = sb.alarm_day;
                            w.hour_now     = sb.alarm_hour;
                            w.minute_now   = sb.alarm_min;
                            w.second_now   = SECOND_W'(s);
                            w.stop_request = pick_stop();
                            send_tick(w);
                        end
                    end
                    else
                    begin
                        // Count seconds through the alarm minute and past the period
                        sow = ((int'(sb.alarm_day) * 24 + int'(sb.alarm_hour)) * 60 +
                               int'(sb.alarm_min)) * 60;
                        sow = (sow + WEEK_SECONDS + $urandom_range(49) - $urandom_range(90))
                              % WEEK_SECONDS;
                        len = $urandom_range(130, 70);
                        repeat (len)
                        begin
                            send_tick(time_word(sow, pick_stop()));
                            sow = (sow + 1) % WEEK_SECONDS;
                        end
                    end
                end
                else if (pick < 80)
                begin
                    // Cross a window boundary by seconds or by minutes
                    if ($urandom_range(1) != 0)
                        bound_min = 60 * int'(sb.window.start_hour) +
                                    int'(sb.window.start_minute);
                    else
                        bound_min = 60 * int'(sb.window.end_hour) + int'(sb.window.end_minute);
                    bound_min = bound_min % 1440;
                    if ($urandom_range(2) == 0)
                    begin
                        step = 60;
                        back = $urandom_range(6) * 60 + $urandom_range(59);
                        len  = $urandom_range(30, 8);
                    end
                    else
                    begin
                        step = 1;
                        back = $urandom_range(150);
                        len  = $urandom_range(200, 60);
                    end
                    sow = ($urandom_range(6) * DAY_SECONDS + bound_min * 60 + WEEK_SECONDS -
                           back) % WEEK_SECONDS;
                    repeat (len)
                    begin
                        send_tick(time_word(sow, pick_stop()));
                        sow = (sow + step) % WEEK_SECONDS;
                    end
                end
                else
                begin
                    // Raw words over the full field widths
                    repeat ($urandom_range(10, 1))
                    begin
                        raw = IN_W'($urandom());
                        w   = raw;
                        w.stop_request = pick_stop();
                        send_tick(w);
                    end
                end
            end
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Run covered %0d ticks in %0d register phases: %0d alarms started, %0d stops",
                 sb.ticks_noted, PHASE_COUNT, sb.alarms_started, sb.stops_seen);
        $display("Night window: %0d entries, %0d exits; %0d status words checked, %0d bad",
                 sb.entries, sb.exits, sb.words_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
